FILE: src/memory_map_table_carver_core_macros.svh
// Assertion macros for the memory map table carver.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MEMORY_MAP_TABLE_CARVER_CORE_MACROS_SVH
`define MEMORY_MAP_TABLE_CARVER_CORE_MACROS_SVH

// same-cycle implication
`define MMTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mmtc_pkg.sv
// Shared types, codes and helpers for the memory map table carver.
// No dependencies.
package mmtc_pkg;

  localparam int unsigned MEM_AW_MAX = 10;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CARVE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_IDX  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [7:0]  kind;
    logic [63:0] length;
    logic [63:0] base;
  } entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [MEM_AW_MAX-1:0] rd_addr;
    logic                  wr_en;
    logic [MEM_AW_MAX-1:0] wr_addr;
    entry_t                wr_data;
  } mem_req_t;

  // end of [b, b+l), saturated at the top of the address space
  function automatic logic [63:0] sat_end(input logic [63:0] b, input logic [63:0] l);
    logic [64:0] s;
    s = {1'b0, b} + {1'b0, l};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

FILE: src/mmtc_if.sv
// Handshake channels of the memory map table carver: request and result.
// Depends on nothing.
interface mmtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] range_base;
  logic [63:0] range_length;
  logic [7:0]  range_type;
  logic [6:0]  read_index;
  modport source (output valid, action, range_base, range_length, range_type, read_index,
                  input ready);
  modport sink   (input valid, action, range_base, range_length, range_type, read_index,
                  output ready);
endinterface

interface mmtc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] entry_base;
  logic [63:0] entry_length;
  logic [7:0]  entry_kind;
  logic [6:0]  next_index;
  logic [1:0]  status;
  logic [7:0]  entry_count;
  modport source (output valid, entry_base, entry_length, entry_kind, next_index, status,
                  entry_count, input ready);
  modport sink   (input valid, entry_base, entry_length, entry_kind, next_index, status,
                  entry_count, output ready);
endinterface

FILE: src/mmtc_mem.sv
// Entry table memory: one write port, one registered read port.
// Depends on mmtc_pkg.
module mmtc_mem import mmtc_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;
endmodule

FILE: src/mmtc_ctrl.sv
// Sequencer for append, read, clear and the carve walk over the table.
// Depends on mmtc_pkg and drives mmtc_mem through a mem_req_t.
module mmtc_ctrl import mmtc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 128,
  parameter int unsigned CNT_W       = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       avail,
  mmtc_in_if.sink          in_ch,
  mmtc_out_if.source       out_ch,
  output mem_req_t         mreq,
  input  entry_t           rd_data,
  output logic [CNT_W-1:0] cnt
);
  localparam int unsigned CMP_W = CNT_W + 8;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_ENTRIES);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RDWAIT = 9'b000000010,
    S_CLOOP  = 9'b000000100,
    S_CWAIT  = 9'b000001000,
    S_CDEC   = 9'b000010000,
    S_SPLIT2 = 9'b000100000,
    S_SHIFT  = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [63:0]      s_r, s_nxt, e_r, e_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [7:0]       t_r, t_nxt;
  entry_t           tail_r, tail_nxt;
  logic [63:0]      ob_r, ob_nxt, ol_r, ol_nxt;
  logic [7:0]       ok_r, ok_nxt;
  logic [6:0]       on_r, on_nxt;
  logic [1:0]       st_r, st_nxt;

  logic [CMP_W-1:0] ri_w, nx_w, cnt_w, i_w, j_w, n_w;
  logic             covered, split, front, back;

  assign ri_w  = CMP_W'(in_ch.read_index);
  assign nx_w  = ri_w + CMP_W'(1);
  assign cnt_w = CMP_W'(cnt_r);
  assign i_w   = CMP_W'(i_r);
  assign j_w   = CMP_W'(j_r);
  assign n_w   = CMP_W'(n_r);

  assign covered = (s_r <= a_r) && (b_r <= e_r);
  assign split   = (a_r < s_r) && (e_r < b_r);
  assign front   = (s_r <= a_r) && (a_r < e_r);
  assign back    = (a_r < s_r) && (s_r < b_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r;
    s_nxt = s_r; e_nxt = e_r; a_nxt = a_r; b_nxt = b_r; t_nxt = t_r;
    tail_nxt = tail_r;
    ob_nxt = ob_r; ol_nxt = ol_r; ok_nxt = ok_r; on_nxt = on_r; st_nxt = st_r;
    mreq = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ob_nxt = '0; ol_nxt = '0; ok_nxt = '0; on_nxt = '0; st_nxt = ST_OK;
          state_nxt = S_DONE;
          case (action_t'(in_ch.action))
            ACT_APPEND: begin
              if (cnt_r >= MAXC) begin
                st_nxt = ST_FULL;
              end else begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = MEM_AW_MAX'(cnt_r);
                mreq.wr_data = '{kind: in_ch.range_type, length: in_ch.range_length,
                                 base: in_ch.range_base};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            ACT_CARVE: begin
              s_nxt = in_ch.range_base;
              e_nxt = sat_end(in_ch.range_base, in_ch.range_length);
              n_nxt = cnt_r;
              i_nxt = '0;
              if (in_ch.range_length != 64'd0) begin
                state_nxt = S_CLOOP;
              end
            end
            ACT_READ: begin
              if (ri_w >= cnt_w) begin
                st_nxt = ST_IDX;
                on_nxt = in_ch.read_index;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = MEM_AW_MAX'(in_ch.read_index);
                on_nxt = (nx_w == cnt_w) ? 7'd0 : nx_w[6:0];
                state_nxt = S_RDWAIT;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        ob_nxt = rd_data.base;
        ol_nxt = rd_data.length;
        ok_nxt = rd_data.kind;
        state_nxt = S_DONE;
      end
      S_CLOOP: begin
        if (i_r >= n_r) begin
          cnt_nxt = n_r;
          state_nxt = S_DONE;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = MEM_AW_MAX'(i_r);
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        a_nxt = rd_data.base;
        t_nxt = rd_data.kind;
        b_nxt = sat_end(rd_data.base, rd_data.length);
        state_nxt = S_CDEC;
      end
      S_CDEC: begin
        state_nxt = S_CLOOP;
        if (t_r != avail) begin
          i_nxt = i_r + CNT_W'(1);
        end else if (covered) begin
          if (i_w + CMP_W'(1) < n_w) begin
            // shift the entries above down by one
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = MEM_AW_MAX'(i_r + CNT_W'(1));
            j_nxt = i_r;
            state_nxt = S_SHIFT;
          end else begin
            n_nxt = n_r - CNT_W'(1);
          end
        end else if (split) begin
          if (n_r >= MAXC) begin
            st_nxt = ST_FULL;   // count stays at its old value
            state_nxt = S_DONE;
          end else begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = MEM_AW_MAX'(i_r);
            mreq.wr_data = '{kind: t_r, length: s_r - a_r, base: a_r};
            tail_nxt = '{kind: t_r, length: b_r - e_r, base: e_r};
            state_nxt = S_SPLIT2;
          end
        end else if (front) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = MEM_AW_MAX'(i_r);
          mreq.wr_data = '{kind: t_r, length: b_r - e_r, base: e_r};
          i_nxt = i_r + CNT_W'(1);
        end else if (back) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = MEM_AW_MAX'(i_r);
          mreq.wr_data = '{kind: t_r, length: s_r - a_r, base: a_r};
          i_nxt = i_r + CNT_W'(1);
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      S_SPLIT2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = MEM_AW_MAX'(n_r);
        mreq.wr_data = tail_r;
        n_nxt = n_r + CNT_W'(1);
        i_nxt = i_r + CNT_W'(1);
        state_nxt = S_CLOOP;
      end
      S_SHIFT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = MEM_AW_MAX'(j_r);
        mreq.wr_data = rd_data;
        if (j_w + CMP_W'(2) < n_w) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = MEM_AW_MAX'(j_r + CNT_W'(2));
          j_nxt = j_r + CNT_W'(1);
        end else begin
          n_nxt = n_r - CNT_W'(1);
          state_nxt = S_CLOOP;   // revisit the same index
        end
      end
      S_DONE: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt;
    s_r <= s_nxt; e_r <= e_nxt; a_r <= a_nxt; b_r <= b_nxt; t_r <= t_nxt;
    tail_r <= tail_nxt;
    ob_r <= ob_nxt; ol_r <= ol_nxt; ok_r <= ok_nxt; on_r <= on_nxt; st_r <= st_nxt;
  end

  logic [CNT_W+7:0] cnt_ext;
  assign cnt_ext = (CNT_W + 8)'(cnt_r);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_DONE);
  assign out_ch.entry_base   = ob_r;
  assign out_ch.entry_length = ol_r;
  assign out_ch.entry_kind   = ok_r;
  assign out_ch.next_index   = on_r;
  assign out_ch.status       = st_r;
  assign out_ch.entry_count  = cnt_ext[7:0];
  assign cnt                 = cnt_r;
endmodule

FILE: src/memory_map_table_carver_core.sv
// Memory map table carver. One item at a time, one result per item. Append, clear, an
// out-of-range read and a zero-length carve go from accept to the result; a read waits for
// the memory read. Any other carve visits each entry in S_CLOOP, S_CWAIT and S_CDEC, plus
// S_SPLIT2 per split and S_SHIFT per removed entry (the shift down); a stalled result
// holds the block until it is taken. It is paced by the single read port and single write
// port of the entry memory, which every step goes through. No clearing pass after reset.
// Depends on mmtc_pkg, mmtc_if, mmtc_mem, mmtc_ctrl and the assertion macro header.
`include "memory_map_table_carver_core_macros.svh"
module memory_map_table_carver_core import mmtc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  mmtc_in_if.sink    in_ch,
  mmtc_out_if.source out_ch
);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [7:0]       avail_r;
  mem_req_t         mreq;
  entry_t           rd_data;
  logic [CNT_W-1:0] cnt;
  logic             clear_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= 8'd1;
    end else if (cfg_we) begin
      avail_r <= cfg_wdata;
    end
  end

  mmtc_mem #(.DEPTH(MAX_ENTRIES)) u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  mmtc_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .CNT_W(CNT_W)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .avail   (avail_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mreq    (mreq),
    .rd_data (rd_data),
    .cnt     (cnt)
  );

  assign clear_acc = in_ch.valid && in_ch.ready && (in_ch.action == ACT_CLEAR);

  `MMTC_ASSERT_NOW(a_one_item, out_ch.valid, !in_ch.ready, "item taken while result pending")
  `MMTC_ASSERT_NOW(a_cnt_max, 1'b1, cnt <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
  `MMTC_ASSERT_NEXT(a_clear, clear_acc, out_ch.valid && out_ch.entry_count == 8'd0, "clear failed")
endmodule
